>>> rtl/core/fdct_pkg.sv
// ----------------------------------------------------------------------------
// fdct_pkg
// shared constants, codes and controller/datapath handshake types for the
// fault debounce counter table
// ----------------------------------------------------------------------------
package fdct_pkg;

  // table geometry
  localparam int NUM_FAULTS = 64;
  localparam int IDX_W      = (NUM_FAULTS > 1) ? $clog2(NUM_FAULTS) : 1;

  // field widths
  localparam int CNT_W      = 16;
  localparam int THD_W      = 15;
  localparam int STEP_W     = 16;
  localparam int FIDX_W     = 6;
  localparam int SUM_W      = CNT_W + 2;

  localparam logic [THD_W-1:0] THD_RESET = THD_W'(127);

  // operation codes
  localparam logic [1:0] OP_REPORT    = 2'd0;
  localparam logic [1:0] OP_EVALUATE  = 2'd1;
  localparam logic [1:0] OP_CLEAR_ALL = 2'd2;
  localparam logic [1:0] OP_CLEAR_SAT = 2'd3;

  // monitor status codes
  localparam logic [2:0] MS_FAILED    = 3'd0;
  localparam logic [2:0] MS_PASSED    = 3'd1;
  localparam logic [2:0] MS_PREFAILED = 3'd2;
  localparam logic [2:0] MS_PREPASSED = 3'd3;
  localparam logic [2:0] MS_INIT      = 3'd4;

  // table read address source
  typedef enum logic [1:0] {
    RA_IN   = 2'd0,
    RA_ZERO = 2'd1,
    RA_WALK = 2'd2,
    RA_IDX  = 2'd3
  } rd_sel_t;

  // controller -> datapath
  typedef struct packed {
    logic    in_ready;
    logic    capture;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    walk_clr;
    logic    walk_step;
    logic    calc;
  } fdct_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_valid;
    logic in_is_clear;
    logic walk_last;
    logic out_free;
  } fdct_sts_t;

endpackage

>>> rtl/core/fdct_in_if.sv
// ----------------------------------------------------------------------------
// fdct_in_if
// request channel: one operation item per valid/ready handshake
// ----------------------------------------------------------------------------
interface fdct_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [5:0]  fault_index;
  logic [2:0]  monitor_status;
  logic [15:0] increment_step;
  logic [15:0] decrement_step;
  logic        keep_on_reverse;
  logic        reset_on_init;
  logic        stored_status_present;

  modport source (
    output valid, operation, fault_index, monitor_status, increment_step,
           decrement_step, keep_on_reverse, reset_on_init, stored_status_present,
    input  ready
  );

  modport sink (
    input  valid, operation, fault_index, monitor_status, increment_step,
           decrement_step, keep_on_reverse, reset_on_init, stored_status_present,
    output ready
  );
endinterface

>>> rtl/core/fdct_out_if.sv
// ----------------------------------------------------------------------------
// fdct_out_if
// result channel: one result item per valid/ready handshake
// ----------------------------------------------------------------------------
interface fdct_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] counter_value;
  logic               limit_up;
  logic               limit_down;
  logic               first_detect_event;
  logic               reached_up_event;
  logic               reached_either_event;
  logic               status_error;

  modport source (
    output valid, counter_value, limit_up, limit_down, first_detect_event,
           reached_up_event, reached_either_event, status_error,
    input  ready
  );

  modport sink (
    input  valid, counter_value, limit_up, limit_down, first_detect_event,
           reached_up_event, reached_either_event, status_error,
    output ready
  );
endinterface

>>> rtl/core/fdct_ctrl.sv
// ----------------------------------------------------------------------------
// fdct_ctrl
// sequencer: single entry read-modify-write and whole-table walk
// ----------------------------------------------------------------------------
module fdct_ctrl
  import fdct_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  fdct_sts_t  sts,
  output fdct_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WALK = 4'b0010,
    S_LOOK = 4'b0100,
    S_CALC = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.rd_sel    = RA_IN;
    unique case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          cmd.capture = 1'b1;
          cmd.rd_en   = 1'b1;
          if (sts.in_is_clear) begin
            cmd.rd_sel   = RA_ZERO;
            cmd.walk_clr = 1'b1;
            state_nxt    = S_WALK;
          end else begin
            cmd.rd_sel = RA_IN;
            state_nxt  = S_CALC;
          end
        end
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_last) begin
          state_nxt = S_LOOK;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_WALK;
        end
      end
      S_LOOK: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_IDX;
        state_nxt  = S_CALC;
      end
      S_CALC: begin
        if (sts.out_free) begin
          cmd.calc  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/fdct_dp.sv
// ----------------------------------------------------------------------------
// fdct_dp
// datapath: counter table, previous-flag table, debounce arithmetic,
// threshold register and result register
// ----------------------------------------------------------------------------
module fdct_dp
  import fdct_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [THD_W-1:0]  cfg_wr_data,
  fdct_in_if.sink           in_chan,
  fdct_out_if.source        out_chan,
  input  fdct_cmd_t         cmd,
  output fdct_sts_t         sts
);

  typedef struct packed {
    logic signed [CNT_W-1:0] cnt;
    logic                    up;
    logic                    dn;
  } main_word_t;

  typedef struct packed {
    logic up;
    logic dn;
    logic pos;
  } prev_word_t;

  // tables and their valid bits
  main_word_t main_mem [NUM_FAULTS];
  prev_word_t prev_mem [NUM_FAULTS];
  logic [NUM_FAULTS-1:0] main_vld_r, main_vld_nxt;
  logic [NUM_FAULTS-1:0] prev_vld_r, prev_vld_nxt;

  main_word_t rd_main_r;
  prev_word_t rd_prev_r;
  logic       rd_mvld_r, rd_pvld_r;

  logic [THD_W-1:0] thd_r;
  logic [IDX_W-1:0] walk_r;

  // latched item
  logic [1:0]        op_r;
  logic [FIDX_W-1:0] idx_r;
  logic [2:0]        ms_r;
  logic [STEP_W-1:0] inc_r, dec_r;
  logic              keep_r, init_clr_r, stored_r;

  // output register
  logic                    out_valid_r;
  logic signed [CNT_W-1:0] o_cnt_r;
  logic                    o_up_r, o_dn_r, o_first_r, o_rup_r, o_reither_r, o_err_r;

  logic [15:0]      in_idx_ext, idx_ext;
  logic [IDX_W-1:0] in_addr, idx_addr, rd_addr, wr_addr;
  logic             idx_ok;
  main_word_t       cur, main_wdata;
  prev_word_t       prv, prev_wdata;
  logic             main_we, prev_we, clr_hit;

  logic signed [SUM_W-1:0] c_x, thd_x, v, base;
  logic signed [CNT_W-1:0] thd_c, new_cnt;
  logic                    new_up, new_dn, err, pos, first, rup, reither;

  assign in_idx_ext = 16'(in_chan.fault_index);
  assign idx_ext    = 16'(idx_r);
  assign in_addr    = in_idx_ext[IDX_W-1:0];
  assign idx_addr   = idx_ext[IDX_W-1:0];
  assign idx_ok     = idx_ext < 16'(NUM_FAULTS);

  assign in_chan.ready = cmd.in_ready;

  assign sts.in_valid    = in_chan.valid;
  assign sts.in_is_clear = (in_chan.operation == OP_CLEAR_ALL) ||
                           (in_chan.operation == OP_CLEAR_SAT);
  assign sts.walk_last   = walk_r == IDX_W'(NUM_FAULTS - 1);
  assign sts.out_free    = !out_valid_r || out_chan.ready;

  always_comb begin
    unique case (cmd.rd_sel)
      RA_IN:   rd_addr = in_addr;
      RA_ZERO: rd_addr = '0;
      RA_WALK: rd_addr = IDX_W'(walk_r + 1'b1);
      RA_IDX:  rd_addr = idx_addr;
      default: rd_addr = in_addr;
    endcase
  end

  // entries never written read as zero
  assign cur = rd_mvld_r ? rd_main_r : '0;
  assign prv = rd_pvld_r ? rd_prev_r : '0;

  // report arithmetic
  assign c_x   = {{(SUM_W-CNT_W){cur.cnt[CNT_W-1]}}, cur.cnt};
  assign thd_x = {{(SUM_W-THD_W){1'b0}}, thd_r};
  assign thd_c = {1'b0, thd_r};

  always_comb begin
    err  = 1'b0;
    base = c_x;
    unique case (ms_r)
      MS_FAILED:    v = thd_x;
      MS_PASSED:    v = -thd_x;
      MS_PREFAILED: begin
        base = (cur.cnt > 0) ? c_x : '0;
        v    = base + {{(SUM_W-STEP_W){1'b0}}, inc_r};
      end
      MS_PREPASSED: begin
        base = (!keep_r && cur.cnt > 0) ? '0 : c_x;
        v    = base - {{(SUM_W-STEP_W){1'b0}}, dec_r};
      end
      MS_INIT:      v = init_clr_r ? '0 : c_x;
      default: begin
        v   = c_x;
        err = 1'b1;
      end
    endcase
  end

  // saturation, upper bound checked first
  always_comb begin
    if (v >= thd_x) begin
      new_cnt = thd_c;
      new_up  = 1'b1;
      new_dn  = 1'b0;
    end else if (v <= -thd_x) begin
      new_cnt = -thd_c;
      new_up  = 1'b0;
      new_dn  = 1'b1;
    end else begin
      new_cnt = v[CNT_W-1:0];
      new_up  = 1'b0;
      new_dn  = 1'b0;
    end
  end

  // evaluate edges
  assign pos     = cur.cnt > 0;
  assign first   = pos && !prv.pos && !stored_r;
  assign rup     = cur.up && !prv.up;
  assign reither = rup || (cur.dn && !prv.dn);

  // table writes
  assign clr_hit = (op_r == OP_CLEAR_ALL) || (cur.cnt == thd_c) || (cur.cnt == -thd_c);

  always_comb begin
    main_we    = 1'b0;
    wr_addr    = idx_addr;
    main_wdata = '0;
    if (cmd.walk_step) begin
      main_we = clr_hit;
      wr_addr = walk_r;
    end else if (cmd.calc && op_r == OP_REPORT && idx_ok) begin
      main_we    = 1'b1;
      main_wdata = '{cnt: new_cnt, up: new_up, dn: new_dn};
    end
  end

  assign prev_we    = cmd.calc && op_r == OP_EVALUATE && idx_ok;
  assign prev_wdata = '{up: cur.up, dn: cur.dn, pos: pos};

  always_comb begin
    main_vld_nxt = main_vld_r;
    prev_vld_nxt = prev_vld_r;
    if (main_we) main_vld_nxt[wr_addr] = 1'b1;
    if (prev_we) prev_vld_nxt[idx_addr] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (main_we) main_mem[wr_addr] <= main_wdata;
    if (prev_we) prev_mem[idx_addr] <= prev_wdata;
    if (cmd.rd_en) begin
      rd_main_r <= main_mem[rd_addr];
      rd_prev_r <= prev_mem[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r  <= '0;
      prev_vld_r  <= '0;
      rd_mvld_r   <= 1'b0;
      rd_pvld_r   <= 1'b0;
      thd_r       <= THD_RESET;
      walk_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      prev_vld_r <= prev_vld_nxt;
      if (cmd.rd_en) begin
        rd_mvld_r <= main_vld_r[rd_addr];
        rd_pvld_r <= prev_vld_r[rd_addr];
      end
      if (cfg_wr_en) thd_r <= cfg_wr_data;
      if (cmd.walk_clr) begin
        walk_r <= '0;
      end else if (cmd.walk_step) begin
        walk_r <= IDX_W'(walk_r + 1'b1);
      end
      if (cmd.calc) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r       <= in_chan.operation;
      idx_r      <= in_chan.fault_index;
      ms_r       <= in_chan.monitor_status;
      inc_r      <= in_chan.increment_step;
      dec_r      <= in_chan.decrement_step;
      keep_r     <= in_chan.keep_on_reverse;
      init_clr_r <= in_chan.reset_on_init;
      stored_r   <= in_chan.stored_status_present;
    end
    if (cmd.calc) begin
      // report gives the saturated value, other operations the entry as read
      o_cnt_r     <= !idx_ok ? '0 : (op_r == OP_REPORT) ? new_cnt : cur.cnt;
      o_up_r      <= idx_ok && ((op_r == OP_REPORT) ? new_up : cur.up);
      o_dn_r      <= idx_ok && ((op_r == OP_REPORT) ? new_dn : cur.dn);
      o_err_r     <= idx_ok && (op_r == OP_REPORT) && err;
      // events only on evaluate
      o_first_r   <= idx_ok && (op_r == OP_EVALUATE) && first;
      o_rup_r     <= idx_ok && (op_r == OP_EVALUATE) && rup;
      o_reither_r <= idx_ok && (op_r == OP_EVALUATE) && reither;
    end
  end

  assign out_chan.valid                = out_valid_r;
  assign out_chan.counter_value        = o_cnt_r;
  assign out_chan.limit_up             = o_up_r;
  assign out_chan.limit_down           = o_dn_r;
  assign out_chan.first_detect_event   = o_first_r;
  assign out_chan.reached_up_event     = o_rup_r;
  assign out_chan.reached_either_event = o_reither_r;
  assign out_chan.status_error         = o_err_r;

endmodule

>>> rtl/core/fault_debounce_counter_table.sv
// ----------------------------------------------------------------------------
// fault_debounce_counter_table
// per-fault signed debounce counters with limit flags and evaluate events
// ----------------------------------------------------------------------------
// One signed counter per fault, saturating at +/- cfg threshold (reset 127).
// Each accepted item gives exactly one result item. A report or evaluate is a
// read-modify-write of the addressed table entry (accept with table read,
// then compute/write/load result), one item at a time; the compute step
// waits while the result register still holds an untaken item.
// Clear-all and clear-saturated walk the whole table through its read and
// write ports one entry per cycle. A new item can be accepted while the
// previous result is still waiting at the output. The threshold register is
// written with cfg_wr_en and must only change while the block is idle. No
// clearing pass is needed after reset: per-entry valid bits make unwritten
// entries read as zero.
// ----------------------------------------------------------------------------
module fault_debounce_counter_table
  import fdct_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // threshold register write
  input  logic              cfg_wr_en,
  input  logic [THD_W-1:0]  cfg_wr_data,
  // request items
  fdct_in_if.sink           in_chan,
  // result items
  fdct_out_if.source        out_chan
);

  // command and status between sequencer and datapath
  fdct_cmd_t cmd;
  fdct_sts_t sts;

  // sequencer: idle / walk / look-up / compute
  fdct_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  // tables, arithmetic, threshold and output register
  fdct_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule
